@@ src/csc_pkg.sv @@
// Shared definitions for the color space converter pipeline.
// Request codes, result flag struct and hue scale helpers; no dependencies.
`default_nettype none

package csc_pkg;

    localparam int CHANNEL_BITS_DEF      = 12;
    localparam int HUE_FRACTION_BITS_DEF = 4;
    localparam int REQ_W                 = 3;

    localparam logic [REQ_W-1:0] REQ_HSV2RGB = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RGB2HSV = 3'd1;
    localparam logic [REQ_W-1:0] REQ_HSL2RGB = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RGB2HSL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CMY2RGB = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RGB2CMY = 3'd5;

    typedef struct packed {
        logic is_hue;
        logic hue_neg;
        logic hue_zero;
        logic sat_zero;
    } t_flags;

    function automatic int hue_full(input int hf);
        return 360 << hf;
    endfunction

    function automatic int hue_sector(input int hf);
        return 60 << hf;
    endfunction

    // Quotient bits of the divider: enough for a saturation and for a hue offset.
    function automatic int div_qbits(input int n, input int hf);
        return (n > 6 + hf) ? n : 6 + hf;
    endfunction

endpackage

`default_nettype wire

@@ src/csc_front.sv @@
// Front end of the converter: six register stages that reduce the hue, find max and min,
// compute chroma, the hue-to-RGB and CMY results, and prepare the divider operands. Uses csc_pkg.
`default_nettype none

module csc_front #(
    parameter int CHANNEL_BITS      = csc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = csc_pkg::HUE_FRACTION_BITS_DEF,
    parameter int QUOT_BITS         = csc_pkg::div_qbits(CHANNEL_BITS, HUE_FRACTION_BITS)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic [csc_pkg::REQ_W-1:0]            i_req_type,
    input  wire logic [HUE_FRACTION_BITS+8:0]         i_hue_in,
    input  wire logic [CHANNEL_BITS-1:0]              i_chan_a,
    input  wire logic [CHANNEL_BITS-1:0]              i_chan_b,
    input  wire logic [CHANNEL_BITS-1:0]              i_chan_c,
    output logic                                      o_valid,
    output csc_pkg::t_flags                           o_flags,
    output logic [HUE_FRACTION_BITS+8:0]              o_hue_base,
    output logic [CHANNEL_BITS+QUOT_BITS-1:0]         o_hue_dvd,
    output logic [CHANNEL_BITS-1:0]                   o_hue_dvs,
    output logic [CHANNEL_BITS+QUOT_BITS-1:0]         o_sat_dvd,
    output logic [CHANNEL_BITS-1:0]                   o_sat_dvs,
    output logic [CHANNEL_BITS-1:0]                   o_out_a,
    output logic [CHANNEL_BITS-1:0]                   o_out_b,
    output logic [CHANNEL_BITS-1:0]                   o_out_c
);
    import csc_pkg::*;

    localparam int N    = CHANNEL_BITS;
    localparam int HF   = HUE_FRACTION_BITS;
    localparam int HB   = 9 + HF;
    localparam int QB   = QUOT_BITS;
    localparam int DW   = N + QB;
    localparam int HQ   = 6 + HF;
    localparam int SECT = hue_sector(HF);
    localparam int FULL = hue_full(HF);
    localparam int TW   = N + 4;
    localparam int KR   = N + 8;
    localparam int MW   = N + 5;
    localparam int MR   = (1 << KR) / 15;
    localparam int FW   = $bits(t_flags);
    localparam int PW   = FW + HB + DW + N + DW + N + 3 * N;

    localparam logic [N-1:0]  CMAX   = {N{1'b1}};
    localparam logic [HB-1:0] H_FULL = HB'(FULL);
    localparam logic [HQ-1:0] Q_SECT = HQ'(SECT);
    localparam logic [MW-1:0] RECIP  = MW'(MR);

    typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} t_maxsel;

    // ---------------- stage 1 ----------------
    logic [HB-1:0]    h_red, h_off;
    logic [2:0]       sec;
    logic [N-1:0]     mx, mn, dlt, den_c, den_l, mop, nabs;
    logic [N:0]       sum_c, sum_l, ndiff;
    logic             nneg;
    t_maxsel          msel;
    logic [2*N-1:0]   prod_c;

    always_comb begin
        h_red = (i_hue_in >= H_FULL) ? i_hue_in - H_FULL : i_hue_in;
        sec   = '0;
        h_off = '0;
        for (int k = 1; k < 6; k++) begin
            if (h_red >= HB'(k * SECT)) begin
                sec   = 3'(k);
                h_off = HB'(k * SECT);
            end
        end

        mx = i_chan_a;
        if (i_chan_b > mx) mx = i_chan_b;
        if (i_chan_c > mx) mx = i_chan_c;
        mn = i_chan_a;
        if (i_chan_b < mn) mn = i_chan_b;
        if (i_chan_c < mn) mn = i_chan_c;
        dlt = mx - mn;

        // Ties in the maximum go to red first, then green.
        if (i_chan_a == mx) begin
            msel  = MAX_RED;
            ndiff = {1'b0, i_chan_b} - {1'b0, i_chan_c};
        end else if (i_chan_b == mx) begin
            msel  = MAX_GREEN;
            ndiff = {1'b0, i_chan_c} - {1'b0, i_chan_a};
        end else begin
            msel  = MAX_BLUE;
            ndiff = {1'b0, i_chan_a} - {1'b0, i_chan_b};
        end
        nneg = ndiff[N];
        nabs = nneg ? N'(~ndiff + (N+1)'(1)) : ndiff[N-1:0];

        sum_c = {1'b0, mx} + {1'b0, mn};
        den_c = (sum_c > {1'b0, CMAX}) ? N'({CMAX, 1'b0} - sum_c) : sum_c[N-1:0];
        sum_l = {i_chan_b, 1'b0};
        den_l = (sum_l > {1'b0, CMAX}) ? N'({CMAX, 1'b0} - sum_l) : sum_l[N-1:0];

        mop    = (i_req_type == REQ_HSL2RGB) ? den_l : i_chan_b;
        prod_c = (2*N)'(mop) * (2*N)'(i_chan_a);
    end

    logic                 r1_valid, r1_nneg;
    logic [REQ_W-1:0]     r1_req;
    logic [2:0]           r1_sec;
    logic [HQ-1:0]        r1_f;
    logic [2*N-1:0]       r1_prod;
    logic [N-1:0]         r1_a, r1_b, r1_c, r1_mx, r1_dlt, r1_den, r1_nabs;
    logic [N:0]           r1_sum;
    t_maxsel              r1_msel;

    // ---------------- stage 2 ----------------
    logic [2*N-1:0]   acc;
    logic [N-1:0]     q0, sdvs, pa, pb, pc;
    logic [DW-1:0]    hdvd, sdvd;
    logic [HB-1:0]    base;
    t_flags           flg;
    logic [PW-1:0]    pv;

    always_comb begin
        acc  = r1_prod + (r1_prod >> N);
        q0   = acc[2*N-1:N];
        hdvd = DW'(r1_nabs) * DW'(SECT);
        case (r1_msel)
            MAX_RED:   base = r1_nneg ? H_FULL : '0;
            MAX_GREEN: base = HB'(2 * SECT);
            MAX_BLUE:  base = HB'(4 * SECT);
            default:   base = '0;
        endcase
        sdvs = (r1_req == REQ_RGB2HSV) ? r1_mx : r1_den;
        sdvd = (DW'(r1_dlt) << N) - DW'(r1_dlt);

        flg.is_hue   = (r1_req == REQ_RGB2HSV) || (r1_req == REQ_RGB2HSL);
        flg.hue_neg  = r1_nneg;
        flg.hue_zero = (r1_dlt == '0);
        flg.sat_zero = (sdvs == '0);

        pa = '0;
        pb = '0;
        pc = '0;
        case (r1_req)
            REQ_RGB2HSV: pb = r1_mx;
            REQ_RGB2HSL: pb = r1_sum[N:1];
            REQ_CMY2RGB, REQ_RGB2CMY: begin
                pa = CMAX - r1_a;
                pb = CMAX - r1_b;
                pc = CMAX - r1_c;
            end
            default: ;
        endcase
        pv = {flg, base, hdvd, r1_dlt, sdvd, sdvs, pa, pb, pc};
    end

    logic                 r2_valid;
    logic [REQ_W-1:0]     r2_req;
    logic [2:0]           r2_sec;
    logic [HQ-1:0]        r2_f;
    logic [2*N-1:0]       r2_prod;
    logic [N-1:0]         r2_q0, r2_b;
    logic [PW-1:0]        r2_pv;

    // ---------------- stage 3: correct the chroma quotient ----------------
    logic [2*N-1:0]   crem;
    logic [N-1:0]     chroma;

    always_comb begin
        crem   = r2_prod - ((2*N)'(r2_q0) << N) + (2*N)'(r2_q0);
        chroma = r2_q0 + N'(crem >= (2*N)'(CMAX));
    end

    logic                 r3_valid;
    logic [REQ_W-1:0]     r3_req;
    logic [2:0]           r3_sec;
    logic [HQ-1:0]        r3_f;
    logic [N-1:0]         r3_b, r3_chroma;
    logic [PW-1:0]        r3_pv;

    // ---------------- stage 4: chroma times sector offset ----------------
    logic [HQ-1:0]    gfac;
    logic [N+HQ-1:0]  xprod;
    logic [TW-1:0]    tq;

    always_comb begin
        gfac  = r3_sec[0] ? Q_SECT - r3_f : r3_f;
        xprod = (N+HQ)'(r3_chroma) * (N+HQ)'(gfac);
        // The sector size is 15 times a power of two; the power of two is a shift.
        tq    = xprod[N+HQ-1:2+HF];
    end

    logic                 r4_valid;
    logic [REQ_W-1:0]     r4_req;
    logic [2:0]           r4_sec;
    logic [N-1:0]         r4_b, r4_chroma;
    logic [TW-1:0]        r4_t;
    logic [PW-1:0]        r4_pv;

    // ---------------- stage 5: divide by 15 through a reciprocal ----------------
    logic [TW+MW-1:0] rprod;
    logic [N-1:0]     x0;

    always_comb begin
        rprod = (TW+MW)'(r4_t) * (TW+MW)'(RECIP);
        x0    = N'(rprod >> KR);
    end

    logic                 r5_valid;
    logic [REQ_W-1:0]     r5_req;
    logic [2:0]           r5_sec;
    logic [N-1:0]         r5_b, r5_chroma, r5_x0;
    logic [TW-1:0]        r5_t;
    logic [PW-1:0]        r5_pv;

    // ---------------- stage 6: place components and form the outputs ----------------
    logic [TW-1:0]    xrem;
    logic [N-1:0]     xv;
    logic [N-1:0]     comp [3];
    logic [N-1:0]     res  [3];
    logic [N+1:0]     acc_v;
    t_flags           f6;
    logic [HB-1:0]    base6;
    logic [DW-1:0]    hdvd6, sdvd6;
    logic [N-1:0]     hdvs6, sdvs6, pa6, pb6, pc6;

    always_comb begin
        {f6, base6, hdvd6, hdvs6, sdvd6, sdvs6, pa6, pb6, pc6} = r5_pv;
        xrem = r5_t - ((TW'(r5_x0) << 4) - TW'(r5_x0));
        xv   = r5_x0 + N'(xrem >= TW'(15));

        case (r5_sec)
            3'd0:    begin comp[0] = r5_chroma; comp[1] = xv;        comp[2] = '0;        end
            3'd1:    begin comp[0] = xv;        comp[1] = r5_chroma; comp[2] = '0;        end
            3'd2:    begin comp[0] = '0;        comp[1] = r5_chroma; comp[2] = xv;        end
            3'd3:    begin comp[0] = '0;        comp[1] = xv;        comp[2] = r5_chroma; end
            3'd4:    begin comp[0] = xv;        comp[1] = '0;        comp[2] = r5_chroma; end
            default: begin comp[0] = r5_chroma; comp[1] = '0;        comp[2] = xv;        end
        endcase

        res[0] = pa6;
        res[1] = pb6;
        res[2] = pc6;
        for (int i = 0; i < 3; i++) begin
            acc_v = '0;
            if (r5_req == REQ_HSV2RGB) begin
                acc_v = (N+2)'(comp[i]) + (N+2)'(r5_b) - (N+2)'(r5_chroma);
            end else if (r5_req == REQ_HSL2RGB) begin
                acc_v = ((N+2)'(comp[i]) << 1) + ((N+2)'(r5_b) << 1) - (N+2)'(r5_chroma);
                acc_v = acc_v >> 1;
            end
            if ((r5_req == REQ_HSV2RGB) || (r5_req == REQ_HSL2RGB)) begin
                res[i] = (acc_v > (N+2)'(CMAX)) ? CMAX : acc_v[N-1:0];
            end
        end
    end

    logic                 r6_valid;
    t_flags               r6_flags;
    logic [HB-1:0]        r6_base;
    logic [DW-1:0]        r6_hdvd, r6_sdvd;
    logic [N-1:0]         r6_hdvs, r6_sdvs, r6_a, r6_b, r6_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_req    <= i_req_type;
            r1_sec    <= sec;
            r1_f      <= HQ'(h_red - h_off);
            r1_prod   <= prod_c;
            r1_a      <= i_chan_a;
            r1_b      <= i_chan_b;
            r1_c      <= i_chan_c;
            r1_mx     <= mx;
            r1_sum    <= sum_c;
            r1_dlt    <= dlt;
            r1_den    <= den_c;
            r1_msel   <= msel;
            r1_nabs   <= nabs;
            r1_nneg   <= nneg;

            r2_req    <= r1_req;
            r2_sec    <= r1_sec;
            r2_f      <= r1_f;
            r2_prod   <= r1_prod;
            r2_q0     <= q0;
            r2_b      <= r1_b;
            r2_pv     <= pv;

            r3_req    <= r2_req;
            r3_sec    <= r2_sec;
            r3_f      <= r2_f;
            r3_b      <= r2_b;
            r3_chroma <= chroma;
            r3_pv     <= r2_pv;

            r4_req    <= r3_req;
            r4_sec    <= r3_sec;
            r4_b      <= r3_b;
            r4_chroma <= r3_chroma;
            r4_t      <= tq;
            r4_pv     <= r3_pv;

            r5_req    <= r4_req;
            r5_sec    <= r4_sec;
            r5_b      <= r4_b;
            r5_chroma <= r4_chroma;
            r5_t      <= r4_t;
            r5_x0     <= x0;
            r5_pv     <= r4_pv;

            r6_flags  <= f6;
            r6_base   <= base6;
            r6_hdvd   <= hdvd6;
            r6_hdvs   <= hdvs6;
            r6_sdvd   <= sdvd6;
            r6_sdvs   <= sdvs6;
            r6_a      <= res[0];
            r6_b      <= res[1];
            r6_c      <= res[2];
        end
    end

    assign o_valid    = r6_valid;
    assign o_flags    = r6_flags;
    assign o_hue_base = r6_base;
    assign o_hue_dvd  = r6_hdvd;
    assign o_hue_dvs  = r6_hdvs;
    assign o_sat_dvd  = r6_sdvd;
    assign o_sat_dvs  = r6_sdvs;
    assign o_out_a    = r6_a;
    assign o_out_b    = r6_b;
    assign o_out_c    = r6_c;

endmodule

`default_nettype wire

@@ src/csc_div.sv @@
// Pipelined restoring divider with two lanes (hue offset and saturation), one quotient
// bit per register stage, carrying a sideband word alongside. Uses csc_pkg.
`default_nettype none

module csc_div #(
    parameter int CHANNEL_BITS      = csc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = csc_pkg::HUE_FRACTION_BITS_DEF,
    parameter int QUOT_BITS         = csc_pkg::div_qbits(CHANNEL_BITS, HUE_FRACTION_BITS),
    parameter int SIDE_BITS         = 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [CHANNEL_BITS+QUOT_BITS-1:0] i_hue_dvd,
    input  wire logic [CHANNEL_BITS-1:0]           i_hue_dvs,
    input  wire logic [CHANNEL_BITS+QUOT_BITS-1:0] i_sat_dvd,
    input  wire logic [CHANNEL_BITS-1:0]           i_sat_dvs,
    input  wire logic [SIDE_BITS-1:0]              i_side,
    output logic                                   o_valid,
    output logic [QUOT_BITS-1:0]                   o_hue_quot,
    output logic [CHANNEL_BITS-1:0]                o_hue_rem,
    output logic [QUOT_BITS-1:0]                   o_sat_quot,
    output logic [SIDE_BITS-1:0]                   o_side
);
    import csc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int QB = QUOT_BITS;
    localparam int DW = N + QB;

    logic            r_vld  [QB];
    logic [N-1:0]    r_rem  [QB][2];
    logic [N-1:0]    r_dvs  [QB][2];
    logic [QB-1:0]   r_low  [QB][2];
    logic [QB-1:0]   r_quo  [QB][2];
    logic [SIDE_BITS-1:0] r_side [QB];

    logic [N-1:0]    s_rem  [QB][2];
    logic [N-1:0]    s_dvs  [QB][2];
    logic [QB-1:0]   s_low  [QB][2];
    logic [QB-1:0]   s_quo  [QB][2];
    logic [SIDE_BITS-1:0] s_side [QB];
    logic            s_vld  [QB];

    logic [N-1:0]    n_rem  [QB][2];
    logic [QB-1:0]   n_low  [QB][2];
    logic [QB-1:0]   n_quo  [QB][2];

    always_comb begin
        logic [N:0] t;
        logic       ge;
        for (int s = 0; s < QB; s++) begin
            if (s == 0) begin
                // The quotient fits in QB bits, so the upper dividend bits start below the divisor.
                s_vld[s]    = i_valid;
                s_side[s]   = i_side;
                s_rem[s][0] = i_hue_dvd[DW-1:QB];
                s_rem[s][1] = i_sat_dvd[DW-1:QB];
                s_low[s][0] = i_hue_dvd[QB-1:0];
                s_low[s][1] = i_sat_dvd[QB-1:0];
                s_dvs[s][0] = i_hue_dvs;
                s_dvs[s][1] = i_sat_dvs;
                s_quo[s][0] = '0;
                s_quo[s][1] = '0;
            end else begin
                s_vld[s]  = r_vld[s-1];
                s_side[s] = r_side[s-1];
                for (int l = 0; l < 2; l++) begin
                    s_rem[s][l] = r_rem[s-1][l];
                    s_low[s][l] = r_low[s-1][l];
                    s_dvs[s][l] = r_dvs[s-1][l];
                    s_quo[s][l] = r_quo[s-1][l];
                end
            end
            for (int l = 0; l < 2; l++) begin
                t  = {s_rem[s][l], s_low[s][l][QB-1]};
                ge = (t >= {1'b0, s_dvs[s][l]});
                n_rem[s][l] = ge ? N'(t - {1'b0, s_dvs[s][l]}) : t[N-1:0];
                n_low[s][l] = {s_low[s][l][QB-2:0], 1'b0};
                n_quo[s][l] = {s_quo[s][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QB; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < QB; s++) r_vld[s] <= s_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QB; s++) begin
                r_side[s] <= s_side[s];
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_low[s][l] <= n_low[s][l];
                    r_quo[s][l] <= n_quo[s][l];
                    r_dvs[s][l] <= s_dvs[s][l];
                end
            end
        end
    end

    assign o_valid    = r_vld[QB-1];
    assign o_side     = r_side[QB-1];
    assign o_hue_quot = r_quo[QB-1][0];
    assign o_hue_rem  = r_rem[QB-1][0];
    assign o_sat_quot = r_quo[QB-1][1];

endmodule

`default_nettype wire

@@ src/csc_back.sv @@
// Output stage: turns the hue quotient into the final hue, selects saturation and
// registers the result item. Uses csc_pkg.
`default_nettype none

module csc_back #(
    parameter int CHANNEL_BITS      = csc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = csc_pkg::HUE_FRACTION_BITS_DEF,
    parameter int QUOT_BITS         = csc_pkg::div_qbits(CHANNEL_BITS, HUE_FRACTION_BITS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire csc_pkg::t_flags              i_flags,
    input  wire logic [HUE_FRACTION_BITS+8:0] i_hue_base,
    input  wire logic [QUOT_BITS-1:0]         i_hue_quot,
    input  wire logic [CHANNEL_BITS-1:0]      i_hue_rem,
    input  wire logic [QUOT_BITS-1:0]         i_sat_quot,
    input  wire logic [CHANNEL_BITS-1:0]      i_out_a,
    input  wire logic [CHANNEL_BITS-1:0]      i_out_b,
    input  wire logic [CHANNEL_BITS-1:0]      i_out_c,
    output logic                              o_valid,
    output logic [HUE_FRACTION_BITS+8:0]      o_hue_out,
    output logic [CHANNEL_BITS-1:0]           o_out_a,
    output logic [CHANNEL_BITS-1:0]           o_out_b,
    output logic [CHANNEL_BITS-1:0]           o_out_c
);
    import csc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int HB = 9 + HUE_FRACTION_BITS;
    localparam int QB = QUOT_BITS;
    localparam int HW = ((HB > QB) ? HB : QB) + 1;

    localparam logic [N-1:0] CMAX = {N{1'b1}};

    logic [HW-1:0] hue_w;
    logic [HB-1:0] hue;
    logic [N-1:0]  sat;

    always_comb begin
        // A negative offset floors toward the lower hue, so a nonzero remainder takes one more.
        if (i_flags.hue_neg) begin
            hue_w = HW'(i_hue_base) - HW'(i_hue_quot) - HW'(i_hue_rem != '0);
        end else begin
            hue_w = HW'(i_hue_base) + HW'(i_hue_quot);
        end
        hue = (i_flags.is_hue && !i_flags.hue_zero) ? hue_w[HB-1:0] : '0;

        if (i_flags.sat_zero) begin
            sat = '0;
        end else if (i_sat_quot > QB'(CMAX)) begin
            sat = CMAX;
        end else begin
            sat = i_sat_quot[N-1:0];
        end
    end

    logic          r_valid;
    logic [HB-1:0] r_hue;
    logic [N-1:0]  r_a, r_b, r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue <= hue;
            r_a   <= i_flags.is_hue ? sat : i_out_a;
            r_b   <= i_out_b;
            r_c   <= i_out_c;
        end
    end

    assign o_valid   = r_valid;
    assign o_hue_out = r_hue;
    assign o_out_a   = r_a;
    assign o_out_b   = r_b;
    assign o_out_c   = r_c;

endmodule

`default_nettype wire

@@ src/color_space_converter_top.sv @@
// Color space converter: HSV, HSL and CMY to and from RGB, one pixel per clock. Each
// transfer on the input side yields one result transfer, registered through the six front
// stages, the bit-per-stage divider for hue and saturation (its quotient width Q is the larger
// of CHANNEL_BITS and HUE_FRACTION_BITS + 6) and the output register. A stall on the output
// freezes the whole pipeline; while it is not stalled a new item is taken in every cycle.
`default_nettype none

module color_space_converter_top #(
    parameter int CHANNEL_BITS      = csc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = csc_pkg::HUE_FRACTION_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [csc_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [HUE_FRACTION_BITS+8:0] i_hue_in,
    input  wire logic [CHANNEL_BITS-1:0]      i_chan_a,
    input  wire logic [CHANNEL_BITS-1:0]      i_chan_b,
    input  wire logic [CHANNEL_BITS-1:0]      i_chan_c,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [HUE_FRACTION_BITS+8:0]      o_hue_out,
    output logic [CHANNEL_BITS-1:0]           o_out_a,
    output logic [CHANNEL_BITS-1:0]           o_out_b,
    output logic [CHANNEL_BITS-1:0]           o_out_c
);
    import csc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int HB = 9 + HUE_FRACTION_BITS;
    localparam int QB = div_qbits(CHANNEL_BITS, HUE_FRACTION_BITS);
    localparam int DW = N + QB;
    localparam int FW = $bits(t_flags);
    localparam int SW = FW + HB + 3 * N;

    logic en;

    logic           f_valid;
    t_flags         f_flags;
    logic [HB-1:0]  f_base;
    logic [DW-1:0]  f_hdvd, f_sdvd;
    logic [N-1:0]   f_hdvs, f_sdvs, f_a, f_b, f_c;

    logic           d_valid;
    logic [QB-1:0]  d_hquot, d_squot;
    logic [N-1:0]   d_hrem;
    logic [SW-1:0]  d_side;
    t_flags         d_flags;
    logic [HB-1:0]  d_base;
    logic [N-1:0]   d_a, d_b, d_c;

    // The whole pipeline advances unless a finished result is held by the consumer.
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    csc_front #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUOT_BITS         (QB)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_hue_in   (i_hue_in),
        .i_chan_a   (i_chan_a),
        .i_chan_b   (i_chan_b),
        .i_chan_c   (i_chan_c),
        .o_valid    (f_valid),
        .o_flags    (f_flags),
        .o_hue_base (f_base),
        .o_hue_dvd  (f_hdvd),
        .o_hue_dvs  (f_hdvs),
        .o_sat_dvd  (f_sdvd),
        .o_sat_dvs  (f_sdvs),
        .o_out_a    (f_a),
        .o_out_b    (f_b),
        .o_out_c    (f_c)
    );

    csc_div #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUOT_BITS         (QB),
        .SIDE_BITS         (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (f_valid),
        .i_hue_dvd  (f_hdvd),
        .i_hue_dvs  (f_hdvs),
        .i_sat_dvd  (f_sdvd),
        .i_sat_dvs  (f_sdvs),
        .i_side     ({f_flags, f_base, f_a, f_b, f_c}),
        .o_valid    (d_valid),
        .o_hue_quot (d_hquot),
        .o_hue_rem  (d_hrem),
        .o_sat_quot (d_squot),
        .o_side     (d_side)
    );

    assign {d_flags, d_base, d_a, d_b, d_c} = d_side;

    csc_back #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUOT_BITS         (QB)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d_valid),
        .i_flags    (d_flags),
        .i_hue_base (d_base),
        .i_hue_quot (d_hquot),
        .i_hue_rem  (d_hrem),
        .i_sat_quot (d_squot),
        .i_out_a    (d_a),
        .i_out_b    (d_b),
        .i_out_c    (d_c),
        .o_valid    (o_valid),
        .o_hue_out  (o_hue_out),
        .o_out_a    (o_out_a),
        .o_out_b    (o_out_b),
        .o_out_c    (o_out_c)
    );

endmodule

`default_nettype wire

@@ src/csc_checker.sv @@
// Port-level checks for the color space converter, bound to the top level.
// Depends on csc_pkg and color_space_converter_top.
`default_nettype none

module csc_checker #(
    parameter int CHANNEL_BITS      = csc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = csc_pkg::HUE_FRACTION_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic [csc_pkg::REQ_W-1:0]    i_req_type,
    input wire logic [HUE_FRACTION_BITS+8:0] i_hue_in,
    input wire logic [CHANNEL_BITS-1:0]      i_chan_a,
    input wire logic [CHANNEL_BITS-1:0]      i_chan_b,
    input wire logic [CHANNEL_BITS-1:0]      i_chan_c,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [HUE_FRACTION_BITS+8:0] o_hue_out,
    input wire logic [CHANNEL_BITS-1:0]      o_out_a,
    input wire logic [CHANNEL_BITS-1:0]      o_out_b,
    input wire logic [CHANNEL_BITS-1:0]      o_out_c
);
    import csc_pkg::*;

    localparam int HB = 9 + HUE_FRACTION_BITS;
    localparam logic [HB-1:0] H_FULL = HB'(hue_full(HUE_FRACTION_BITS));

    // The pipeline empties on reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result transfer offered right after reset");

    // Hue is always reduced below one full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_out < H_FULL))
        else $error("hue out of range");

    // A nonzero hue only comes from the RGB-to-hue modes, which leave the third channel zero.
    a_hue_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hue_out != '0)) |-> (o_out_c == '0))
        else $error("hue result with nonzero third channel");

    // A held result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hue_out) && $stable(o_out_a)
                                  && $stable(o_out_b) && $stable(o_out_c)))
        else $error("stalled result changed");

endmodule

bind color_space_converter_top csc_checker #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_csc_checker (.*);

`default_nettype wire

@@ verif/color_space_converter_checker.sv @@
// Checker for the color space converter: watches both channels, predicts each result
// and compares all four fields of it at once. Depends on csc_pkg for the request codes.
`default_nettype none

module color_space_converter_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [12:0] i_hue_in,
    input  wire logic [11:0] i_chan_a,
    input  wire logic [11:0] i_chan_b,
    input  wire logic [11:0] i_chan_c,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [12:0] i_hue_out,
    input  wire logic [11:0] i_out_a,
    input  wire logic [11:0] i_out_b,
    input  wire logic [11:0] i_out_c,
    output int               o_errors,
    output int               o_pending
);
    import csc_pkg::*;

    localparam longint CFULL = 4095;
    localparam longint SECTOR = 960;
    localparam longint TURN = 5760;

    typedef struct packed {
        logic [12:0] hue;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
    } t_pixel;

    t_pixel expected_pixels[$];

    function automatic longint clip(input longint v);
        return (v > CFULL) ? CFULL : v;
    endfunction

    function automatic void place_chroma(input longint h, input longint ch,
                                         output longint r, output longint g,
                                         output longint bl);
        longint sec, f, x;
        sec = h / SECTOR;
        f = h % SECTOR;
        x = sec[0] ? (ch * (SECTOR - f)) / SECTOR : (ch * f) / SECTOR;
        case (sec)
            0: begin r = ch; g = x; bl = 0; end
            1: begin r = x; g = ch; bl = 0; end
            2: begin r = 0; g = ch; bl = x; end
            3: begin r = 0; g = x; bl = ch; end
            4: begin r = x; g = 0; bl = ch; end
            default: begin r = ch; g = 0; bl = x; end
        endcase
    endfunction

    function automatic longint hue_from_rgb(input longint r, input longint g,
                                            input longint bl);
        longint mx, mn, d, h;
        mx = (r > g) ? r : g;
        mx = (mx > bl) ? mx : bl;
        mn = (r < g) ? r : g;
        mn = (mn < bl) ? mn : bl;
        d = mx - mn;
        if (d == 0) return 0;
        if (mx == r) begin
            if (g >= bl) h = ((g - bl) * SECTOR) / d;
            else h = (TURN * d - (bl - g) * SECTOR) / d;
        end else if (mx == g) begin
            h = (2 * SECTOR * d + bl * SECTOR - r * SECTOR) / d;
        end else begin
            h = (4 * SECTOR * d + r * SECTOR - g * SECTOR) / d;
        end
        return h % TURN;
    endfunction

    function automatic t_pixel convert_pixel(input logic [2:0] req, input logic [12:0] hin,
                                             input longint a, input longint b,
                                             input longint c);
        longint h, ch, r, g, bl, mx, mn, d, sum, den;
        longint o0, o1, o2, o3;
        t_pixel p;
        h = longint'(hin) % TURN;
        o0 = 0; o1 = 0; o2 = 0; o3 = 0;
        mx = (a > b) ? a : b;
        mx = (mx > c) ? mx : c;
        mn = (a < b) ? a : b;
        mn = (mn < c) ? mn : c;
        d = mx - mn;
        case (req)
            REQ_HSV2RGB: begin
                ch = (b * a) / CFULL;
                place_chroma(h, ch, r, g, bl);
                o1 = clip(r + b - ch);
                o2 = clip(g + b - ch);
                o3 = clip(bl + b - ch);
            end
            REQ_HSL2RGB: begin
                sum = 2 * b;
                den = (sum > CFULL) ? 2 * CFULL - sum : sum;
                ch = (den * a) / CFULL;
                place_chroma(h, ch, r, g, bl);
                o1 = clip((2 * r + sum - ch) >> 1);
                o2 = clip((2 * g + sum - ch) >> 1);
                o3 = clip((2 * bl + sum - ch) >> 1);
            end
            REQ_RGB2HSV: begin
                o0 = hue_from_rgb(a, b, c);
                o1 = (mx == 0) ? 0 : clip((d * CFULL) / mx);
                o2 = mx;
            end
            REQ_RGB2HSL: begin
                sum = mx + mn;
                den = (sum > CFULL) ? 2 * CFULL - sum : sum;
                o0 = hue_from_rgb(a, b, c);
                o1 = (d == 0 || den == 0) ? 0 : clip((d * CFULL) / den);
                o2 = sum >> 1;
            end
            REQ_CMY2RGB, REQ_RGB2CMY: begin
                o1 = CFULL - a;
                o2 = CFULL - b;
                o3 = CFULL - c;
            end
            default: ;
        endcase
        p.hue = o0[12:0];
        p.a = o1[11:0];
        p.b = o2[11:0];
        p.c = o3[11:0];
        return p;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                expected_pixels = {expected_pixels,
                    convert_pixel(i_req_type, i_hue_in, longint'(i_chan_a),
                                  longint'(i_chan_b), longint'(i_chan_c))};
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transfer: hue %0d a %0d b %0d c %0d",
                                 i_hue_out, i_out_a, i_out_b, i_out_c);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want != {i_hue_out, i_out_a, i_out_b, i_out_c}) begin
                        if (o_errors < 10)
                            $display({"mismatch: expected hue %0d a %0d b %0d c %0d,",
                                      " got hue %0d a %0d b %0d c %0d"},
                                     want.hue, want.a, want.b, want.c,
                                     i_hue_out, i_out_a, i_out_b, i_out_c);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

@@ verif/color_space_converter_top_tb.sv @@
// Testbench top for the color space converter: drives directed and random pixels with
// random idling on both sides. Depends on csc_pkg, the block and the checker module.
`default_nettype none

module color_space_converter_top_tb;
    import csc_pkg::*;

    localparam int LATENCY = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [12:0] hue_in;
    logic [11:0] chan_a, chan_b, chan_c;
    logic        out_valid;
    logic        out_stall;
    logic [12:0] hue_out;
    logic [11:0] out_a, out_b, out_c;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          calm_phase;

    color_space_converter_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_req_type(req_type), .i_hue_in(hue_in), .i_chan_a(chan_a),
        .i_chan_b(chan_b), .i_chan_c(chan_c), .o_valid(out_valid),
        .i_stall(out_stall), .o_hue_out(hue_out), .o_out_a(out_a),
        .o_out_b(out_b), .o_out_c(out_c)
    );

    color_space_converter_checker pixel_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_req_type(req_type), .i_hue_in(hue_in), .i_chan_a(chan_a),
        .i_chan_b(chan_b), .i_chan_c(chan_c), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_hue_out(hue_out), .i_out_a(out_a),
        .i_out_b(out_b), .i_out_c(out_c), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Receiver stalls in bursts; none during the calm phase.
    initial begin
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (!calm_phase && $urandom_range(0, 9) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    // Counts cycles in which no transfer happens on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_pixel(input logic [2:0] req, input logic [12:0] h,
                              input logic [11:0] a, input logic [11:0] b,
                              input logic [11:0] c);
        if (!calm_phase && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1;
        req_type <= req;
        hue_in <= h;
        chan_a <= a;
        chan_b <= b;
        chan_c <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [11:0] a, b, c;
        logic [12:0] h;
        int pick;
        pick = $urandom_range(0, 9);
        a = 12'($urandom); b = 12'($urandom); c = 12'($urandom); h = 13'($urandom);
        // Ties and extremes reach the equal-max and zero-delta hue paths.
        if (pick == 0) b = a;
        else if (pick == 1) c = a;
        else if (pick == 2) begin b = a; c = a; end
        else if (pick == 3) a = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
        send_pixel(3'($urandom_range(0, 7)), h, a, b, c);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [2:0] req;
        calm_phase = 0;
        rst_n = 0;
        in_valid = 0;
        req_type = REQ_HSV2RGB;
        hue_in = 0;
        chan_a = 0;
        chan_b = 0;
        chan_c = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int r = 0; r < 8; r++) begin
            req = 3'(r);
            send_pixel(req, 13'h1FFF, 12'hFFF, 12'hFFF, 12'hFFF);
            send_pixel(req, 13'd0, 12'h000, 12'h000, 12'h000);
        end
        send_pixel(REQ_HSV2RGB, 13'd5760, 12'hFFF, 12'h800, 12'h000);
        send_pixel(REQ_HSL2RGB, 13'd5759, 12'hFFF, 12'h7FF, 12'h000);
        send_pixel(REQ_HSL2RGB, 13'd960, 12'h123, 12'hFFF, 12'h000);
        send_pixel(REQ_RGB2HSV, 13'd0, 12'hFFF, 12'h000, 12'h001);
        send_pixel(REQ_RGB2HSV, 13'd0, 12'h400, 12'hFFF, 12'hFFF);
        send_pixel(REQ_RGB2HSL, 13'd0, 12'h100, 12'h200, 12'hFFF);
        send_pixel(REQ_RGB2HSL, 13'd0, 12'hFFF, 12'hFFF, 12'hFFE);
        send_pixel(REQ_CMY2RGB, 13'h0AAA, 12'hAAA, 12'h555, 12'hAAA);
        send_pixel(REQ_RGB2CMY, 13'h1555, 12'h555, 12'hAAA, 12'h555);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain();
            if (i == RANDOM_ITEMS - 60) calm_phase = 1;
            send_random_pixel();
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
src/csc_pkg.sv
src/csc_front.sv
src/csc_div.sv
src/csc_back.sv
src/color_space_converter_top.sv
src/csc_checker.sv
verif/color_space_converter_checker.sv
verif/color_space_converter_top_tb.sv
